// File: rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the two-level cache tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

    localparam int ADDR_W = 64;
    localparam int TAG_W  = 62;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam int L2_MAX_SETS_DEF = 1024;
    localparam int L2_MAX_WAYS_DEF = 8;
    localparam int L3_MAX_SETS_DEF = 2048;
    localparam int L3_MAX_WAYS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SET_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_SET_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_WAYS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_OFFSET_BITS = 3'd5;

    localparam logic [3:0] RST_L2_SET_BITS    = 4'd10;
    localparam logic [3:0] RST_L2_WAYS        = 4'd8;
    localparam logic [3:0] RST_L2_OFFSET_BITS = 4'd6;
    localparam logic [3:0] RST_L3_SET_BITS    = 4'd11;
    localparam logic [4:0] RST_L3_WAYS        = 5'd16;
    localparam logic [3:0] RST_L3_OFFSET_BITS = 4'd6;

    localparam logic [3:0] OFFSET_MIN = 4'd2;
    localparam logic [3:0] OFFSET_MAX = 4'd12;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_L2_META,
        ST_L2_SCAN,
        ST_L2_CMP,
        ST_L3_META,
        ST_L3_SCAN,
        ST_L3_CMP,
        ST_L3_VIC,
        ST_L3_FILL,
        ST_L2_PICK,
        ST_L2_VIC,
        ST_L2_FILL,
        ST_DONE
    } state_t;

    function automatic logic [3:0] clamp_offset(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < OFFSET_MIN) r = OFFSET_MIN;
        if (v > OFFSET_MAX) r = OFFSET_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/two_level_cache_lru_lookup.sv
// Flow: one transaction in flight, ways probed one per step through a single tag
// compare; the next input is accepted no earlier than the cycle in which the result shows.
// Reset: valid/age rows swept to zero over max(L2, L3 sets) rows (2048); s_ready low.
// ----------------------------------------------------------------------------
// two_level_cache_lru_lookup
// Tag and LRU state of a non-inclusive L2/L3 pair, one miss address per
// transaction, way-serial lookup and fill with victim reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_cache_lru_lookup #(
    parameter int L2_MAX_SETS = tcl_pkg::L2_MAX_SETS_DEF,
    parameter int L2_MAX_WAYS = tcl_pkg::L2_MAX_WAYS_DEF,
    parameter int L3_MAX_SETS = tcl_pkg::L3_MAX_SETS_DEF,
    parameter int L3_MAX_WAYS = tcl_pkg::L3_MAX_WAYS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcl_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [tcl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tcl_pkg::ADDR_W-1:0]      s_address,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_l2_hit,
    output logic                                 m_l3_hit,
    output logic [2:0]                           m_l2_way,
    output logic [3:0]                           m_l3_way,
    output logic                                 m_l2_evicted,
    output logic [tcl_pkg::TAG_W-1:0]            m_l2_victim_tag,
    output logic                                 m_l3_evicted,
    output logic [tcl_pkg::TAG_W-1:0]            m_l3_victim_tag
);
    import tcl_pkg::*;

    localparam int L2_CAP = $clog2(L2_MAX_SETS + 1) - 1;
    localparam int L3_CAP = $clog2(L3_MAX_SETS + 1) - 1;
    localparam int S2W = (L2_CAP > 0) ? L2_CAP : 1;
    localparam int S3W = (L3_CAP > 0) ? L3_CAP : 1;
    localparam int W2I = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
    localparam int W3I = (L3_MAX_WAYS > 1) ? $clog2(L3_MAX_WAYS) : 1;
    localparam int W2C = $clog2(L2_MAX_WAYS + 1);
    localparam int W3C = $clog2(L3_MAX_WAYS + 1);
    localparam int SCW = (W2C > W3C) ? W2C : W3C;
    localparam int CLW = (S2W > S3W) ? S2W : S3W;
    localparam int M2W = L2_MAX_WAYS * (1 + W2I);
    localparam int M3W = L3_MAX_WAYS * (1 + W3I);
    localparam int T2A = S2W + W2I;
    localparam int T3A = S3W + W3I;

    // ---------------- configuration registers ----------------
    logic [3:0] l2_set_bits_reg, l2_ways_reg, l2_off_reg;
    logic [3:0] l3_set_bits_reg, l3_off_reg;
    logic [4:0] l3_ways_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l2_set_bits_reg <= RST_L2_SET_BITS;
            l2_ways_reg     <= RST_L2_WAYS;
            l2_off_reg      <= RST_L2_OFFSET_BITS;
            l3_set_bits_reg <= RST_L3_SET_BITS;
            l3_ways_reg     <= RST_L3_WAYS;
            l3_off_reg      <= RST_L3_OFFSET_BITS;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_L2_SET_BITS:    l2_set_bits_reg <= cfg_data[3:0];
                CFG_L2_WAYS:        l2_ways_reg     <= cfg_data[3:0];
                CFG_L2_OFFSET_BITS: l2_off_reg      <= cfg_data[3:0];
                CFG_L3_SET_BITS:    l3_set_bits_reg <= cfg_data[3:0];
                CFG_L3_WAYS:        l3_ways_reg     <= cfg_data;
                CFG_L3_OFFSET_BITS: l3_off_reg      <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- memories ----------------
    logic [TAG_W-1:0] tag2_mem [2**T2A];
    logic [TAG_W-1:0] tag3_mem [2**T3A];
    logic [M2W-1:0]   meta2_mem [2**S2W];
    logic [M3W-1:0]   meta3_mem [2**S3W];

    logic [TAG_W-1:0] tag2_rd_reg, tag3_rd_reg;
    logic [M2W-1:0]   meta2_rd_reg;
    logic [M3W-1:0]   meta3_rd_reg;

    logic [T2A-1:0]   tag2_raddr, tag2_waddr;
    logic [T3A-1:0]   tag3_raddr, tag3_waddr;
    logic             tag2_we, tag3_we;
    logic [TAG_W-1:0] tag2_wdata, tag3_wdata;
    logic [S2W-1:0]   meta2_raddr, meta2_waddr;
    logic [S3W-1:0]   meta3_waddr;
    logic             meta2_we, meta3_we;
    logic [M2W-1:0]   meta2_wdata;
    logic [M3W-1:0]   meta3_wdata;

    // ---------------- state registers ----------------
    state_t state_reg, state_next;
    logic [CLW-1:0]    clr_reg, clr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TAG_W-1:0]  tag2_reg, tag2_next, tag3_reg, tag3_next;
    logic [S2W-1:0]    set2_reg, set2_next;
    logic [S3W-1:0]    set3_reg, set3_next;
    logic [W2C-1:0]    w2_reg, w2_next;
    logic [W3C-1:0]    w3_reg, w3_next;
    logic [SCW-1:0]    scan_reg, scan_next;

    logic [L2_MAX_WAYS-1:0]             v2_reg, v2_next;
    logic [L2_MAX_WAYS-1:0][W2I-1:0]    r2_reg, r2_next;
    logic [L3_MAX_WAYS-1:0]             v3_reg, v3_next;
    logic [L3_MAX_WAYS-1:0][W3I-1:0]    r3_reg, r3_next;

    logic           inv2_reg, inv2_next, inv3_reg, inv3_next;
    logic [W2I-1:0] inv2_way_reg, inv2_way_next, lru2_way_reg, lru2_way_next;
    logic [W3I-1:0] inv3_way_reg, inv3_way_next, lru3_way_reg, lru3_way_next;
    logic [W2I-1:0] lru2_rank_reg, lru2_rank_next;
    logic [W3I-1:0] lru3_rank_reg, lru3_rank_next;

    // result accumulation and output register
    logic             l2_hit_reg, l2_hit_next, l3_hit_reg, l3_hit_next;
    logic [W2I-1:0]   l2_way_reg, l2_way_next;
    logic [W3I-1:0]   l3_way_reg, l3_way_next;
    logic             ev2_reg, ev2_next, ev3_reg, ev3_next;
    logic [TAG_W-1:0] vic2_reg, vic2_next, vic3_reg, vic3_next;

    logic             m_valid_reg, m_valid_next;
    logic             o_l2_hit_reg, o_l2_hit_next, o_l3_hit_reg, o_l3_hit_next;
    logic [2:0]       o_l2_way_reg, o_l2_way_next;
    logic [3:0]       o_l3_way_reg, o_l3_way_next;
    logic             o_ev2_reg, o_ev2_next, o_ev3_reg, o_ev3_next;
    logic [TAG_W-1:0] o_vic2_reg, o_vic2_next, o_vic3_reg, o_vic3_next;

    // ---------------- address decode ----------------
    logic [3:0]        o2, o3;
    logic [4:0]        s2, s3;
    logic [ADDR_W-1:0] sh_set2, sh_set3, sh_tag2, sh_tag3;
    logic [W2C-1:0]    dec_w2;
    logic [W3C-1:0]    dec_w3;

    always_comb begin
        o2 = clamp_offset(l2_off_reg);
        o3 = clamp_offset(l3_off_reg);
        s2 = (32'(l2_set_bits_reg) > L2_CAP) ? 5'(L2_CAP) : 5'(l2_set_bits_reg);
        s3 = (32'(l3_set_bits_reg) > L3_CAP) ? 5'(L3_CAP) : 5'(l3_set_bits_reg);
        sh_set2 = (addr_reg >> o2) & ((64'd1 << s2) - 64'd1);
        sh_set3 = (addr_reg >> o3) & ((64'd1 << s3) - 64'd1);
        sh_tag2 = addr_reg >> (6'(o2) + 6'(s2));
        sh_tag3 = addr_reg >> (6'(o3) + 6'(s3));
        if (l2_ways_reg == 4'd0)               dec_w2 = W2C'(1);
        else if (32'(l2_ways_reg) > L2_MAX_WAYS) dec_w2 = W2C'(L2_MAX_WAYS);
        else                                    dec_w2 = W2C'(l2_ways_reg);
        if (l3_ways_reg == 5'd0)               dec_w3 = W3C'(1);
        else if (32'(l3_ways_reg) > L3_MAX_WAYS) dec_w3 = W3C'(L3_MAX_WAYS);
        else                                    dec_w3 = W3C'(l3_ways_reg);
    end

    // ---------------- age update (one row, all ways side by side) ----------------
    logic [W2I-1:0]  idx2, vic2_way, t2_way;
    logic [W3I-1:0]  idx3, vic3_way, t3_way;
    logic [L2_MAX_WAYS-1:0]          new_v2;
    logic [L2_MAX_WAYS-1:0][W2I-1:0] new_r2;
    logic [L3_MAX_WAYS-1:0]          new_v3;
    logic [L3_MAX_WAYS-1:0][W3I-1:0] new_r3;
    logic [31:0] old_r2, old_r3;

    assign idx2     = scan_reg[W2I-1:0];
    assign idx3     = scan_reg[W3I-1:0];
    assign vic2_way = inv2_reg ? inv2_way_reg : lru2_way_reg;
    assign vic3_way = inv3_reg ? inv3_way_reg : lru3_way_reg;
    assign t2_way   = (state_reg == ST_L2_CMP) ? idx2 : vic2_way;
    assign t3_way   = (state_reg == ST_L3_CMP) ? idx3 : vic3_way;

    always_comb begin
        new_v2 = v2_reg;
        new_r2 = r2_reg;
        old_r2 = v2_reg[t2_way] ? 32'(r2_reg[t2_way]) : 32'hFF;
        for (int i = 0; i < L2_MAX_WAYS; i++) begin
            if (i < 32'(w2_reg) && i != 32'(t2_way) && v2_reg[i] &&
                32'(r2_reg[i]) < old_r2 && 32'(r2_reg[i]) < L2_MAX_WAYS - 1) begin
                new_r2[i] = r2_reg[i] + W2I'(1);
            end
        end
        new_r2[t2_way] = '0;
        new_v2[t2_way] = 1'b1;
    end

    always_comb begin
        new_v3 = v3_reg;
        new_r3 = r3_reg;
        old_r3 = v3_reg[t3_way] ? 32'(r3_reg[t3_way]) : 32'hFF;
        for (int i = 0; i < L3_MAX_WAYS; i++) begin
            if (i < 32'(w3_reg) && i != 32'(t3_way) && v3_reg[i] &&
                32'(r3_reg[i]) < old_r3 && 32'(r3_reg[i]) < L3_MAX_WAYS - 1) begin
                new_r3[i] = r3_reg[i] + W3I'(1);
            end
        end
        new_r3[t3_way] = '0;
        new_v3[t3_way] = 1'b1;
    end

    // ---------------- sequencer ----------------
    logic [31:0] o_way2_ext, o_way3_ext;
    logic        scan2_end, scan3_end;

    assign scan2_end = (32'(scan_reg) == 32'(w2_reg));
    assign scan3_end = (32'(scan_reg) == 32'(w3_reg));
    assign o_way2_ext = 32'(l2_way_reg);
    assign o_way3_ext = 32'(l3_way_reg);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        tag2_next      = tag2_reg;
        tag3_next      = tag3_reg;
        set2_next      = set2_reg;
        set3_next      = set3_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        scan_next      = scan_reg;
        v2_next        = v2_reg;
        r2_next        = r2_reg;
        v3_next        = v3_reg;
        r3_next        = r3_reg;
        inv2_next      = inv2_reg;
        inv3_next      = inv3_reg;
        inv2_way_next  = inv2_way_reg;
        inv3_way_next  = inv3_way_reg;
        lru2_way_next  = lru2_way_reg;
        lru3_way_next  = lru3_way_reg;
        lru2_rank_next = lru2_rank_reg;
        lru3_rank_next = lru3_rank_reg;
        l2_hit_next    = l2_hit_reg;
        l3_hit_next    = l3_hit_reg;
        l2_way_next    = l2_way_reg;
        l3_way_next    = l3_way_reg;
        ev2_next       = ev2_reg;
        ev3_next       = ev3_reg;
        vic2_next      = vic2_reg;
        vic3_next      = vic3_reg;
        m_valid_next   = m_valid_reg;
        o_l2_hit_next  = o_l2_hit_reg;
        o_l3_hit_next  = o_l3_hit_reg;
        o_l2_way_next  = o_l2_way_reg;
        o_l3_way_next  = o_l3_way_reg;
        o_ev2_next     = o_ev2_reg;
        o_ev3_next     = o_ev3_reg;
        o_vic2_next    = o_vic2_reg;
        o_vic3_next    = o_vic3_reg;

        tag2_raddr  = {set2_reg, idx2};
        tag3_raddr  = {set3_reg, idx3};
        tag2_we     = 1'b0;
        tag3_we     = 1'b0;
        tag2_waddr  = {set2_reg, vic2_way};
        tag3_waddr  = {set3_reg, vic3_way};
        tag2_wdata  = tag2_reg;
        tag3_wdata  = tag3_reg;
        meta2_raddr = set2_reg;
        meta2_we    = 1'b0;
        meta3_we    = 1'b0;
        meta2_waddr = set2_reg;
        meta3_waddr = set3_reg;
        meta2_wdata = {new_v2, new_r2};
        meta3_wdata = {new_v3, new_r3};

        s_ready = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                meta2_we    = 1'b1;
                meta3_we    = 1'b1;
                meta2_waddr = clr_reg[S2W-1:0];
                meta3_waddr = clr_reg[S3W-1:0];
                meta2_wdata = '0;
                meta3_wdata = '0;
                clr_next    = clr_reg + CLW'(1);
                if (&clr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next   = s_address;
                    l2_hit_next = 1'b0;
                    l3_hit_next = 1'b0;
                    l3_way_next = '0;
                    ev2_next    = 1'b0;
                    ev3_next    = 1'b0;
                    vic2_next   = '0;
                    vic3_next   = '0;
                    state_next  = ST_DEC;
                end
            end
            ST_DEC: begin
                set2_next   = sh_set2[S2W-1:0];
                set3_next   = sh_set3[S3W-1:0];
                tag2_next   = sh_tag2[TAG_W-1:0];
                tag3_next   = sh_tag3[TAG_W-1:0];
                w2_next     = dec_w2;
                w3_next     = dec_w3;
                meta2_raddr = sh_set2[S2W-1:0];
                state_next  = ST_L2_META;
            end
            ST_L2_META: begin
                {v2_next, r2_next} = meta2_rd_reg;
                scan_next  = '0;
                inv2_next  = 1'b0;
                state_next = ST_L2_SCAN;
            end
            ST_L2_SCAN: begin
                if (scan2_end) begin
                    state_next = ST_L3_META;
                end else begin
                    if (!v2_reg[idx2] && !inv2_reg) begin
                        inv2_next     = 1'b1;
                        inv2_way_next = idx2;
                    end
                    // lowest way wins among equal ranks
                    if (scan_reg == '0 || r2_reg[idx2] > lru2_rank_reg) begin
                        lru2_way_next  = idx2;
                        lru2_rank_next = r2_reg[idx2];
                    end
                    if (v2_reg[idx2]) begin
                        state_next = ST_L2_CMP;
                    end else begin
                        scan_next = scan_reg + SCW'(1);
                    end
                end
            end
            ST_L2_CMP: begin
                if (tag2_rd_reg == tag2_reg) begin
                    meta2_we    = 1'b1;
                    l2_hit_next = 1'b1;
                    l2_way_next = idx2;
                    state_next  = ST_DONE;
                end else begin
                    scan_next  = scan_reg + SCW'(1);
                    state_next = ST_L2_SCAN;
                end
            end
            ST_L3_META: begin
                {v3_next, r3_next} = meta3_rd_reg;
                scan_next  = '0;
                inv3_next  = 1'b0;
                state_next = ST_L3_SCAN;
            end
            ST_L3_SCAN: begin
                if (scan3_end) begin
                    tag3_raddr = {set3_reg, lru3_way_reg};
                    state_next = inv3_reg ? ST_L3_FILL : ST_L3_VIC;
                end else begin
                    if (!v3_reg[idx3] && !inv3_reg) begin
                        inv3_next     = 1'b1;
                        inv3_way_next = idx3;
                    end
                    if (scan_reg == '0 || r3_reg[idx3] > lru3_rank_reg) begin
                        lru3_way_next  = idx3;
                        lru3_rank_next = r3_reg[idx3];
                    end
                    if (v3_reg[idx3]) begin
                        state_next = ST_L3_CMP;
                    end else begin
                        scan_next = scan_reg + SCW'(1);
                    end
                end
            end
            ST_L3_CMP: begin
                if (tag3_rd_reg == tag3_reg) begin
                    meta3_we    = 1'b1;
                    l3_hit_next = 1'b1;
                    l3_way_next = idx3;
                    state_next  = ST_L2_PICK;
                end else begin
                    scan_next  = scan_reg + SCW'(1);
                    state_next = ST_L3_SCAN;
                end
            end
            ST_L3_VIC: begin
                ev3_next   = 1'b1;
                vic3_next  = tag3_rd_reg;
                state_next = ST_L3_FILL;
            end
            ST_L3_FILL: begin
                tag3_we     = 1'b1;
                meta3_we    = 1'b1;
                l3_way_next = vic3_way;
                state_next  = ST_L2_PICK;
            end
            ST_L2_PICK: begin
                tag2_raddr = {set2_reg, lru2_way_reg};
                state_next = inv2_reg ? ST_L2_FILL : ST_L2_VIC;
            end
            ST_L2_VIC: begin
                ev2_next   = 1'b1;
                vic2_next  = tag2_rd_reg;
                state_next = ST_L2_FILL;
            end
            ST_L2_FILL: begin
                tag2_we     = 1'b1;
                meta2_we    = 1'b1;
                l2_way_next = vic2_way;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    o_l2_hit_next = l2_hit_reg;
                    o_l3_hit_next = l3_hit_reg;
                    o_l2_way_next = o_way2_ext[2:0];
                    o_l3_way_next = o_way3_ext[3:0];
                    o_ev2_next    = ev2_reg;
                    o_ev3_next    = ev3_reg;
                    o_vic2_next   = vic2_reg;
                    o_vic3_next   = vic3_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        tag2_reg      <= tag2_next;
        tag3_reg      <= tag3_next;
        set2_reg      <= set2_next;
        set3_reg      <= set3_next;
        w2_reg        <= w2_next;
        w3_reg        <= w3_next;
        scan_reg      <= scan_next;
        v2_reg        <= v2_next;
        r2_reg        <= r2_next;
        v3_reg        <= v3_next;
        r3_reg        <= r3_next;
        inv2_reg      <= inv2_next;
        inv3_reg      <= inv3_next;
        inv2_way_reg  <= inv2_way_next;
        inv3_way_reg  <= inv3_way_next;
        lru2_way_reg  <= lru2_way_next;
        lru3_way_reg  <= lru3_way_next;
        lru2_rank_reg <= lru2_rank_next;
        lru3_rank_reg <= lru3_rank_next;
        l2_hit_reg    <= l2_hit_next;
        l3_hit_reg    <= l3_hit_next;
        l2_way_reg    <= l2_way_next;
        l3_way_reg    <= l3_way_next;
        ev2_reg       <= ev2_next;
        ev3_reg       <= ev3_next;
        vic2_reg      <= vic2_next;
        vic3_reg      <= vic3_next;
        o_l2_hit_reg  <= o_l2_hit_next;
        o_l3_hit_reg  <= o_l3_hit_next;
        o_l2_way_reg  <= o_l2_way_next;
        o_l3_way_reg  <= o_l3_way_next;
        o_ev2_reg     <= o_ev2_next;
        o_ev3_reg     <= o_ev3_next;
        o_vic2_reg    <= o_vic2_next;
        o_vic3_reg    <= o_vic3_next;
    end

    // memory ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (tag2_we) tag2_mem[tag2_waddr] <= tag2_wdata;
        tag2_rd_reg <= tag2_mem[tag2_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tag3_we) tag3_mem[tag3_waddr] <= tag3_wdata;
        tag3_rd_reg <= tag3_mem[tag3_raddr];
    end

    always_ff @(posedge aclk) begin
        if (meta2_we) meta2_mem[meta2_waddr] <= meta2_wdata;
        meta2_rd_reg <= meta2_mem[meta2_raddr];
    end

    always_ff @(posedge aclk) begin
        if (meta3_we) meta3_mem[meta3_waddr] <= meta3_wdata;
        meta3_rd_reg <= meta3_mem[set3_reg];
    end

    assign m_valid         = m_valid_reg;
    assign m_l2_hit        = o_l2_hit_reg;
    assign m_l3_hit        = o_l3_hit_reg;
    assign m_l2_way        = o_l2_way_reg;
    assign m_l3_way        = o_l3_way_reg;
    assign m_l2_evicted    = o_ev2_reg;
    assign m_l2_victim_tag = o_vic2_reg;
    assign m_l3_evicted    = o_ev3_reg;
    assign m_l3_victim_tag = o_vic3_reg;

endmodule

`default_nettype wire

// File: rtl/tcl_checker.sv
// ----------------------------------------------------------------------------
// tcl_checker
// Port-level checks of the two-level cache tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_l2_hit,
    input wire logic                         m_l3_hit,
    input wire logic [3:0]                   m_l3_way,
    input wire logic                         m_l2_evicted,
    input wire logic [tcl_pkg::TAG_W-1:0]    m_l2_victim_tag,
    input wire logic                         m_l3_evicted,
    input wire logic [tcl_pkg::TAG_W-1:0]    m_l3_victim_tag
);

    // an l2 hit leaves the l3 hit, the l3 way and both eviction flags clear
    a_l2_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_l2_hit |-> !m_l3_hit && !m_l2_evicted && !m_l3_evicted &&
            m_l3_way == 4'd0)
        else $error("l2 hit with l3 or fill fields set");

    a_l3_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_l3_hit |-> !m_l3_evicted && m_l3_victim_tag == '0)
        else $error("l3 hit reports an l3 victim");

    a_l2_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_l2_evicted |-> m_l2_victim_tag == '0)
        else $error("l2 victim tag without eviction");

    // one transaction at a time: input closes right after acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

endmodule

bind two_level_cache_lru_lookup tcl_checker u_tcl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_l2_hit        (m_l2_hit),
    .m_l3_hit        (m_l3_hit),
    .m_l3_way        (m_l3_way),
    .m_l2_evicted    (m_l2_evicted),
    .m_l2_victim_tag (m_l2_victim_tag),
    .m_l3_evicted    (m_l3_evicted),
    .m_l3_victim_tag (m_l3_victim_tag)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level cache tag lookup. Miss addresses are
// driven through the input channel under several register settings, and each
// result is compared field by field against a behavioral LRU tag model, or against the row's own result for typed rows.
// ----------------------------------------------------------------------------
module testbench;
    import tcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 150;
    localparam int N_DIRECTED     = 14;
    localparam int N_PHASES       = 6;

    typedef struct packed {
        bit        l2_hit;
        bit        l3_hit;
        bit [2:0]  l2_way;
        bit [3:0]  l3_way;
        bit        l2_evicted;
        bit [61:0] l2_victim;
        bit        l3_evicted;
        bit [61:0] l3_victim;
    } lookup_res_t;

    typedef struct {
        bit [63:0]   addr;
        bit          typed;
        lookup_res_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [4:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_address;
    logic        m_valid;
    logic        m_ready;
    logic        m_l2_hit;
    logic        m_l3_hit;
    logic [2:0]  m_l2_way;
    logic [3:0]  m_l3_way;
    logic        m_l2_evicted;
    logic [61:0] m_l2_victim_tag;
    logic        m_l3_evicted;
    logic [61:0] m_l3_victim_tag;

    two_level_cache_lru_lookup u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_address(s_address),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_l2_hit(m_l2_hit), .m_l3_hit(m_l3_hit),
        .m_l2_way(m_l2_way), .m_l3_way(m_l3_way),
        .m_l2_evicted(m_l2_evicted), .m_l2_victim_tag(m_l2_victim_tag),
        .m_l3_evicted(m_l3_evicted), .m_l3_victim_tag(m_l3_victim_tag)
    );

    // shadow tag state: index 0 is L2, index 1 is L3
    bit [61:0] tag_mem [2][32768];
    bit        line_vld[2][32768];
    int        line_age[2][32768];

    bit [3:0] l2_set_bits, l2_ways, l2_offset_bits;
    bit [3:0] l3_set_bits, l3_offset_bits;
    bit [4:0] l3_ways;

    lookup_res_t expected_results[$];
    int  errors;
    int  n_results;
    int  n_l2_hits, n_l3_hits, n_evictions;
    int  idle_cycles;
    bit  quiet;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int clamp_val(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int set_bits_cap(int bits, int max_sets);
        int cap;
        cap = 0;
        while (cap < 16 && (1 << (cap + 1)) <= max_sets) cap++;
        return (bits > cap) ? cap : bits;
    endfunction

    function automatic void age_touch(int lv, int base, int ways, int w, int maxw);
        int r;
        r = line_vld[lv][base + w] ? line_age[lv][base + w] : 255;
        for (int i = 0; i < ways; i++) begin
            if (i != w && line_vld[lv][base + i] && line_age[lv][base + i] < r
                && line_age[lv][base + i] < maxw - 1)
                line_age[lv][base + i]++;
        end
        line_age[lv][base + w] = 0;
    endfunction

    function automatic bit level_access(int lv, int base, int ways, int maxw,
                                        bit [61:0] tag, bit fill, bit lookup,
                                        inout int way, output bit ev,
                                        output bit [61:0] vic);
        int best;
        ev  = 1'b0;
        vic = '0;
        if (lookup) begin
            for (int i = 0; i < ways; i++) begin
                if (line_vld[lv][base + i] && tag_mem[lv][base + i] == tag) begin
                    age_touch(lv, base, ways, i, maxw);
                    way = i;
                    return 1'b1;
                end
            end
        end
        if (!fill) return 1'b0;
        best = ways;
        for (int i = 0; i < ways; i++) begin
            if (!line_vld[lv][base + i]) begin
                best = i;
                break;
            end
        end
        if (best == ways) begin
            best = 0;
            for (int i = 1; i < ways; i++)
                if (line_age[lv][base + i] > line_age[lv][base + best]) best = i;
            ev  = 1'b1;
            vic = tag_mem[lv][base + best];
        end
        age_touch(lv, base, ways, best, maxw);
        tag_mem[lv][base + best]  = tag;
        line_vld[lv][base + best] = 1'b1;
        way = best;
        return 1'b0;
    endfunction

    function automatic lookup_res_t cache_lookup(bit [63:0] addr);
        lookup_res_t r;
        int s2, s3, o2, o3, w2, w3, way2, way3, b2, b3;
        bit [61:0] tag2, tag3, vic2, vic3;
        bit hit2, hit3, ev2, ev3;
        s2 = set_bits_cap(l2_set_bits, 1024);
        s3 = set_bits_cap(l3_set_bits, 2048);
        o2 = clamp_val(l2_offset_bits, 2, 12);
        o3 = clamp_val(l3_offset_bits, 2, 12);
        w2 = clamp_val(l2_ways, 1, 8);
        w3 = clamp_val(l3_ways, 1, 16);
        tag2 = 62'(addr >> (o2 + s2));
        tag3 = 62'(addr >> (o3 + s3));
        b2 = int'((addr >> o2) & ((64'd1 << s2) - 1)) * 8;
        b3 = int'((addr >> o3) & ((64'd1 << s3) - 1)) * 16;
        way2 = 0; way3 = 0; hit3 = 0; ev2 = 0; ev3 = 0; vic2 = '0; vic3 = '0;
        hit2 = level_access(0, b2, w2, 8, tag2, 1'b0, 1'b1, way2, ev2, vic2);
        if (!hit2) begin
            hit3 = level_access(1, b3, w3, 16, tag3, 1'b1, 1'b1, way3, ev3, vic3);
            void'(level_access(0, b2, w2, 8, tag2, 1'b1, 1'b0, way2, ev2, vic2));
        end
        r.l2_hit = hit2;      r.l3_hit = hit3;
        r.l2_way = way2[2:0]; r.l3_way = way3[3:0];
        r.l2_evicted = ev2;   r.l2_victim = vic2;
        r.l3_evicted = ev3;   r.l3_victim = vic3;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        lookup_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("result %0d arrived with nothing outstanding", n_results);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_l2_hit !== e.l2_hit) report_mismatch("l2_hit", m_l2_hit, e.l2_hit);
                if (m_l3_hit !== e.l3_hit) report_mismatch("l3_hit", m_l3_hit, e.l3_hit);
                if (m_l2_way !== e.l2_way) report_mismatch("l2_way", m_l2_way, e.l2_way);
                if (m_l3_way !== e.l3_way) report_mismatch("l3_way", m_l3_way, e.l3_way);
                if (m_l2_evicted !== e.l2_evicted)
                    report_mismatch("l2_evicted", m_l2_evicted, e.l2_evicted);
                if (m_l2_victim_tag !== e.l2_victim)
                    report_mismatch("l2_victim_tag", m_l2_victim_tag, e.l2_victim);
                if (m_l3_evicted !== e.l3_evicted)
                    report_mismatch("l3_evicted", m_l3_evicted, e.l3_evicted);
                if (m_l3_victim_tag !== e.l3_victim)
                    report_mismatch("l3_victim_tag", m_l3_victim_tag, e.l3_victim);
            end
            n_results++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result-side backpressure
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
        end
    end

    task automatic write_reg(bit [2:0] idx, bit [4:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_L2_SET_BITS:    l2_set_bits    = val[3:0];
            CFG_L2_WAYS:        l2_ways        = val[3:0];
            CFG_L2_OFFSET_BITS: l2_offset_bits = val[3:0];
            CFG_L3_SET_BITS:    l3_set_bits    = val[3:0];
            CFG_L3_WAYS:        l3_ways        = val;
            CFG_L3_OFFSET_BITS: l3_offset_bits = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drives one address; typed rows override the model's answer
    task automatic send_address(bit [63:0] addr, bit typed, lookup_res_t want);
        lookup_res_t p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = cache_lookup(addr);
        expected_results = {expected_results, (typed ? want : p)};
        if (p.l2_hit) n_l2_hits++;
        if (p.l3_hit) n_l3_hits++;
        if (p.l2_evicted || p.l3_evicted) n_evictions++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    dir_row_t    dir_rows[N_DIRECTED];
    bit [4:0]    phase_cfg[N_PHASES][6];
    bit [63:0]   line_pool[24];
    lookup_res_t none_res;

    initial begin
        bit [23:0] low_pick[2];
        bit [63:0] a;
        errors = 0; n_results = 0; idle_cycles = 0; quiet = 0;
        n_l2_hits = 0; n_l3_hits = 0; n_evictions = 0;
        l2_set_bits = RST_L2_SET_BITS; l2_ways = RST_L2_WAYS;
        l2_offset_bits = RST_L2_OFFSET_BITS; l3_set_bits = RST_L3_SET_BITS;
        l3_ways = RST_L3_WAYS; l3_offset_bits = RST_L3_OFFSET_BITS;
        aresetn = 1'b0; cfg_valid = 1'b0; cfg_addr = '0; cfg_data = '0;
        s_valid = 1'b0; s_address = '0;
        none_res = '0;

        // cold misses, a hit, top and bottom of the address space, then a
        // burst into one set to force LRU victims in L2
        dir_rows[0] = '{64'h0, 1, none_res};
        dir_rows[1] = '{64'h0, 1, lookup_res_t'({1'b1, 1'b0, 3'd0, 4'd0, 1'b0,
                                                 62'd0, 1'b0, 62'd0})};
        dir_rows[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 1, none_res};
        dir_rows[3] = '{64'h8000_0000_0000_0000, 0, none_res};
        dir_rows[4] = '{64'h0000_0000_0000_003F, 0, none_res};
        dir_rows[5] = '{64'h0000_0000_0000_0040, 0, none_res};
        dir_rows[6] = '{64'h0000_0000_0002_0000, 0, none_res};
        for (int i = 7; i < N_DIRECTED; i++)
            dir_rows[i] = '{64'(i - 6) << 20, 0, none_res};

        phase_cfg[0] = '{5'd10, 5'd8, 5'd6, 5'd11, 5'd16, 5'd6};
        phase_cfg[1] = '{5'd0, 5'd1, 5'd2, 5'd0, 5'd1, 5'd2};
        phase_cfg[2] = '{5'd15, 5'd15, 5'd15, 5'd15, 5'd31, 5'd15};
        phase_cfg[3] = '{5'd2, 5'd0, 5'd0, 5'd3, 5'd0, 5'd1};
        phase_cfg[4] = '{5'd4, 5'd3, 5'd12, 5'd5, 5'd5, 5'd12};
        phase_cfg[5] = '{5'd10, 5'd8, 5'd6, 5'd11, 5'd16, 5'd6};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_address(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) quiet = 1;
            write_reg(CFG_L2_SET_BITS,    phase_cfg[ph][0]);
            write_reg(CFG_L2_WAYS,        phase_cfg[ph][1]);
            write_reg(CFG_L2_OFFSET_BITS, phase_cfg[ph][2]);
            write_reg(CFG_L3_SET_BITS,    phase_cfg[ph][3]);
            write_reg(CFG_L3_WAYS,        phase_cfg[ph][4]);
            write_reg(CFG_L3_OFFSET_BITS, phase_cfg[ph][5]);
            // a pool of lines crowding two sets at both levels
            low_pick[0] = 24'($urandom);
            low_pick[1] = 24'($urandom);
            foreach (line_pool[k])
                line_pool[k] = {$urandom, 8'($urandom), low_pick[$urandom_range(0, 1)]};
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 7)
                    a = line_pool[$urandom_range(0, 23)];
                else
                    a = {$urandom, $urandom};
                send_address(a, 0, none_res);
            end
            wait_drained();
        end

        $display("covered %0d lookups over %0d register settings", n_results, N_PHASES);
        $display("l2 hits %0d, l3 hits %0d, lookups with an eviction %0d",
                 n_l2_hits, n_l3_hits, n_evictions);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
